// ----- rtl/edf_pkg.sv -----
// ----------------------------------------------------------------------------
// edf_pkg
// Transfer types, opcodes, controller states and the command and status
// groups shared by the dispatcher modules.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int MISS_W = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  task_index;
    logic [31:0] period_value;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  dispatched_task;
    logic [7:0]  missed_mask;
    logic [3:0]  queue_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_VISIT,
    S_SCAN,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic start_step;
    logic visit;
    logic scan;
    logic pop;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic due_insert;
    logic insert_now;
    logic result_busy;
  } status_t;

endpackage

// ----- rtl/edf_controller.sv -----
// ----------------------------------------------------------------------------
// edf_controller
// Sequencer for load, start and tick transfers; drives datapath commands.
// ----------------------------------------------------------------------------
module edf_controller import edf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic [1:0] opcode,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    item_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch = 1'b1;
          case (opcode)
            OP_TICK:  state_next = S_VISIT;
            OP_START: state_next = S_START;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_START: begin
        cmd.start_step = 1'b1;
        if (stat.last) state_next = S_DONE;
      end
      S_VISIT: begin
        cmd.visit = 1'b1;
        if (stat.due_insert) state_next = S_SCAN;
        else if (stat.last) state_next = S_POP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.insert_now) state_next = stat.last ? S_POP : S_VISIT;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.result_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/edf_datapath.sv -----
// ----------------------------------------------------------------------------
// edf_datapath
// Task tables, ready list, release comparator and result register.
// ----------------------------------------------------------------------------
module edf_datapath import edf_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t stat,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int LEN_W = $clog2(NUM_TASKS + 1);

  logic [31:0]          period   [NUM_TASKS];
  logic [31:0]          rel_time [NUM_TASKS];
  logic [IDX_W-1:0]     list     [NUM_TASKS];
  logic [NUM_TASKS-1:0] queued;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     pos;
  logic [IDX_W-1:0]     idx;
  logic [31:0]          cand;
  logic [31:0]          now_q;
  logic [MISS_W-1:0]    mask;
  logic                 disp;
  logic [2:0]           dtask;

  logic [31:0]      rel_i;
  logic [31:0]      list_rel;
  logic             due;
  logic             pos_end;
  logic [IDX_W-1:0] head;

  assign rel_i    = rel_time[idx];
  assign due      = (rel_i <= now_q);
  assign pos_end  = (pos == len);
  assign list_rel = rel_time[list[pos[IDX_W-1:0]]];
  assign head     = list[0];

  assign stat.last        = (idx == IDX_W'(NUM_TASKS - 1));
  assign stat.due_insert  = due && !queued[idx];
  assign stat.insert_now  = pos_end || (cand < list_rel);
  assign stat.result_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        period[k]   <= '0;
        rel_time[k] <= '0;
        list[k]     <= '0;
      end
      queued       <= '0;
      len          <= '0;
      pos          <= '0;
      idx          <= '0;
      mask         <= '0;
      disp         <= 1'b0;
      dtask        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        now_q <= item.now_time;
        mask  <= '0;
        disp  <= 1'b0;
        dtask <= '0;
        idx   <= '0;
        if (item.opcode == OP_LOAD && 32'(item.task_index) < NUM_TASKS) begin
          period[IDX_W'(item.task_index)] <= item.period_value;
        end
        if (item.opcode == OP_START) begin
          len    <= '0;
          queued <= '0;
        end
      end

      if (cmd.start_step) begin
        rel_time[idx] <= now_q + period[idx];
        idx           <= idx + 1'b1;
      end

      if (cmd.visit) begin
        pos <= '0;
        if (due) begin
          rel_time[idx] <= rel_i + period[idx];
          if (!queued[idx]) begin
            queued[idx] <= 1'b1;
            cand        <= rel_i;
          end else if (32'(idx) < MISS_W) begin
            mask[3'(idx)] <= 1'b1;
          end
        end
        if (!stat.due_insert) idx <= idx + 1'b1;
      end

      if (cmd.scan) begin
        if (stat.insert_now) begin
          if (32'(len) < NUM_TASKS) begin
            for (int k = 1; k < NUM_TASKS; k++) begin
              if (LEN_W'(k) > pos) list[k] <= list[k-1];
            end
            list[pos[IDX_W-1:0]] <= idx;
            len <= len + 1'b1;
          end
          idx <= idx + 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end

      if (cmd.pop && len != '0) begin
        for (int k = 0; k < NUM_TASKS - 1; k++) begin
          list[k] <= list[k+1];
        end
        len          <= len - 1'b1;
        queued[head] <= 1'b0;
        disp         <= 1'b1;
        dtask        <= 3'(head);
      end

      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.dispatched      <= disp;
      result.dispatched_task <= dtask;
      result.missed_mask     <= mask;
      result.queue_count     <= 4'(len);
    end
  end

endmodule

// ----- rtl/edf_periodic_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// edf_periodic_task_dispatcher
// Periodic task dispatcher ordered by next release time.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A start sets the release time of
// every task in turn. A tick visits every task in turn and, for each task
// that enters the ready list, walks the list with a single release
// comparator, one entry per cycle, before placing it. A new transfer is
// taken while the previous result still waits in the output register.
module edf_periodic_task_dispatcher import edf_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  cmd_t    cmd;
  status_t stat;

  edf_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (item.opcode),
    .stat       (stat),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  edf_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
